@@ sv/prq_pkg.sv @@
`timescale 1ns / 1ps
// Package for the priority ready queue: default sizes, status codes and the
// operation struct that the top level hands to every cell. No dependencies.
package prq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int PRIO_BITS_DEFAULT = 8;
    localparam int ID_W              = 8;
    localparam int STATUS_W          = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef struct packed {
        logic enq;
        logic deq;
    } cell_op_t;

endpackage

@@ sv/priority_ready_queue.sv @@
`timescale 1ns / 1ps
// Top level of the priority ready queue: a row of prq_cell slots and the
// registered result beat. Depends on prq_pkg and prq_cell.
//
//   channel  | handshake    | fields
//   ---------+--------------+-------------------------
//   command  | start, busy  | cmd, proc_id, prio
//   result   | done         | out_id, out_prio, status
//
// The result beat for a command shows on done in the next cycle, and busy
// stays low, so a command may be issued on every cycle.
// All cells compare against the new priority at once and shift in one step.
// Reset empties the queue at once. The receiver cannot stall the result.
module priority_ready_queue
    import prq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int PRIO_BITS = PRIO_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cmd,
    input  logic [ID_W-1:0]     proc_id,
    input  logic [7:0]          prio,
    output logic                done,
    output logic [ID_W-1:0]     out_id,
    output logic [7:0]          out_prio,
    output logic [STATUS_W-1:0] status
);

    logic [DEPTH-1:0]     c_valid;
    logic [DEPTH-1:0]     c_gt;
    logic [ID_W-1:0]      c_id   [DEPTH];
    logic [PRIO_BITS-1:0] c_prio [DEPTH];

    logic [PRIO_BITS+7:0] prio_wide;
    logic [PRIO_BITS-1:0] new_prio;
    logic [PRIO_BITS+7:0] head_wide;
    logic                 full;
    logic                 empty;
    cell_op_t             op;

    logic                done_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [ID_W-1:0]     out_id_next;
    logic [7:0]          out_prio_reg;
    logic [7:0]          out_prio_next;
    status_t             status_reg;
    status_t             status_next;

    assign prio_wide = {{PRIO_BITS{1'b0}}, prio};
    assign new_prio  = prio_wide[PRIO_BITS-1:0];
    assign head_wide = {8'd0, c_prio[0]};

    assign full  = c_valid[DEPTH-1];
    assign empty = !c_valid[0];

    assign op.enq = start && (cmd == CMD_ENQ) && !full;
    assign op.deq = start && (cmd == CMD_DEQ) && !empty;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic                 l_valid;
            logic                 l_gt;
            logic [ID_W-1:0]      l_id;
            logic [PRIO_BITS-1:0] l_prio;
            logic                 r_valid;
            logic [ID_W-1:0]      r_id;
            logic [PRIO_BITS-1:0] r_prio;

            if (g == 0)
            begin : g_first
                assign l_valid = 1'b1;
                assign l_gt    = 1'b0;
                assign l_id    = '0;
                assign l_prio  = '0;
            end
            else
            begin : g_mid_l
                assign l_valid = c_valid[g-1];
                assign l_gt    = c_gt[g-1];
                assign l_id    = c_id[g-1];
                assign l_prio  = c_prio[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign r_valid = 1'b0;
                assign r_id    = '0;
                assign r_prio  = '0;
            end
            else
            begin : g_mid_r
                assign r_valid = c_valid[g+1];
                assign r_id    = c_id[g+1];
                assign r_prio  = c_prio[g+1];
            end

            prq_cell #(
                .PRIO_BITS(PRIO_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .new_id     (proc_id),
                .new_prio   (new_prio),
                .left_valid (l_valid),
                .left_gt    (l_gt),
                .left_id    (l_id),
                .left_prio  (l_prio),
                .right_valid(r_valid),
                .right_id   (r_id),
                .right_prio (r_prio),
                .valid      (c_valid[g]),
                .gt         (c_gt[g]),
                .id         (c_id[g]),
                .prio       (c_prio[g])
            );
        end
    endgenerate

    always_comb
    begin
        out_id_next   = '0;
        out_prio_next = '0;
        status_next   = ST_OK;
        case (cmd)
            CMD_ENQ:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
            end
            CMD_DEQ:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    out_id_next   = c_id[0];
                    out_prio_next = head_wide[7:0];
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            out_id_reg   <= out_id_next;
            out_prio_reg <= out_prio_next;
            status_reg   <= status_next;
        end
    end

    assign busy     = 1'b0;
    assign done     = done_reg;
    assign out_id   = out_id_reg;
    assign out_prio = out_prio_reg;
    assign status   = status_reg;

endmodule

@@ sv/prq_cell.sv @@
`timescale 1ns / 1ps
// One slot of the sorted queue: holds an id, a priority and a valid bit, and
// trades data with its neighbors on an enqueue or a dequeue. Depends on prq_pkg.
module prq_cell
    import prq_pkg::*;
#(
    parameter int PRIO_BITS = PRIO_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_op_t             op,
    input  logic [ID_W-1:0]      new_id,
    input  logic [PRIO_BITS-1:0] new_prio,
    input  logic                 left_valid,
    input  logic                 left_gt,
    input  logic [ID_W-1:0]      left_id,
    input  logic [PRIO_BITS-1:0] left_prio,
    input  logic                 right_valid,
    input  logic [ID_W-1:0]      right_id,
    input  logic [PRIO_BITS-1:0] right_prio,
    output logic                 valid,
    output logic                 gt,
    output logic [ID_W-1:0]      id,
    output logic [PRIO_BITS-1:0] prio
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [ID_W-1:0]      id_reg;
    logic [ID_W-1:0]      id_next;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [PRIO_BITS-1:0] prio_next;

    // The new entry goes in front of the first stored entry of lower priority.
    assign gt = valid_reg && (new_prio > prio_reg);

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        if (op.enq)
        begin
            if (left_gt)
            begin
                valid_next = 1'b1;
                id_next    = left_id;
                prio_next  = left_prio;
            end
            else if (gt || (!valid_reg && left_valid))
            begin
                valid_next = 1'b1;
                id_next    = new_id;
                prio_next  = new_prio;
            end
        end
        else if (op.deq)
        begin
            valid_next = right_valid;
            id_next    = right_id;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign prio  = prio_reg;

endmodule
